/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// Concurrent properties sampled on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a general property on the rising clock edge outside of reset.
`define AST_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a signal holds while a request is stalled.
`define AST_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("stalled request changed");

`endif

/* rtl/crc8fr_pkg.sv */
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Types, codes and the CRC-8 step of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

  // Receiver phases.
  typedef enum logic [2:0] {
    PHASE_HUNT = 3'd0,
    PHASE_LEN1 = 3'd1,
    PHASE_LEN2 = 3'd2,
    PHASE_LEN3 = 3'd3,
    PHASE_LEN4 = 3'd4,
    PHASE_CMD  = 3'd5,
    PHASE_DATA = 3'd6,
    PHASE_CRC  = 3'd7
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_COMMIT  = 2'd1,
    STATUS_CRC_BAD = 2'd2,
    STATUS_LEN_BAD = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [0:0] CFG_SYNC_BYTE  = 1'd0;
  localparam logic [0:0] CFG_MAX_LENGTH = 1'd1;

  localparam logic [7:0]  SYNC_BYTE_RESET  = 8'h58;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd2097147;

  // Reflected CRC-8 polynomial (Dallas/Maxim).
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Smallest legal length: command, one data byte, CRC byte.
  localparam logic [31:0] MIN_LENGTH = 32'd3;
  // Command and CRC bytes are not counted in the data phase.
  localparam logic [31:0] OVERHEAD = 32'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_frame;
    status_t    status;
  } result_t;

  // One byte through the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/crc8fr_stream_if.sv */
// ----------------------------------------------------------------------------
// crc8fr_stream_if
// Valid/ready channel that carries one request payload per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crc8fr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/crc8_length_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc8_length_frame_receiver
// Byte-stream deframer: sync byte, 32-bit length, command, data, CRC-8.
// ----------------------------------------------------------------------------
// One received byte goes in per request on rx_chan, and exactly one result
// comes out per byte on frame_chan: the byte itself, an in_frame mark and a
// status code (commit on a good CRC, drop on a bad CRC or a rejected length).
// The block takes a byte every clock cycle; a result appears in the cycle after
// its byte is taken. The per-byte path is one CRC-8 byte step plus 32-bit
// compares, all between the phase registers and the result register. rx_chan
// drops ready only while the result register is full and frame_chan stalls.
// sync_byte and max_length are written through the cfg port; a write takes
// effect at the next byte that looks at that register.
`timescale 1ns / 1ps
`default_nettype none

module crc8_length_frame_receiver (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  crc8fr_stream_if.sink              rx_chan,
  crc8fr_stream_if.source            frame_chan
);

  // Configuration registers.
  logic [7:0]  sync_byte;
  logic [31:0] max_length;

  // Frame tracking state.
  crc8fr_pkg::phase_t phase, phase_next;
  logic [31:0]        byte_count, count_next;
  logic [31:0]        frame_length, length_next;
  logic [31:0]        data_limit, limit_next;
  logic [7:0]         running_crc, crc_next;

  // Result register.
  logic                 out_valid;
  crc8fr_pkg::result_t  out_item;
  crc8fr_pkg::result_t  result_next;

  logic        rx_fire;
  logic [7:0]  c;
  logic [7:0]  crc_step;
  logic [31:0] len_full;

  // Take a new byte whenever the result register is empty or being drained.
  assign rx_chan.ready = !out_valid || frame_chan.ready;
  assign rx_fire       = rx_chan.valid && rx_chan.ready;

  assign frame_chan.valid   = out_valid;
  assign frame_chan.payload = out_item;

  assign c        = rx_chan.payload.rx_byte;
  assign crc_step = crc8fr_pkg::crc8_update(running_crc, c);
  // Length arrives big-endian: shift the new byte in at the bottom.
  assign len_full = {frame_length[23:0], c};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= crc8fr_pkg::SYNC_BYTE_RESET;
      max_length <= crc8fr_pkg::MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == crc8fr_pkg::CFG_SYNC_BYTE) begin
        sync_byte <= cfg_data[7:0];
      end
      if (cfg_index == crc8fr_pkg::CFG_MAX_LENGTH) begin
        max_length <= cfg_data;
      end
    end
  end

  // Next phase and the result for the byte on rx_chan.
  always_comb begin
    phase_next  = phase;
    count_next  = byte_count;
    length_next = frame_length;
    limit_next  = data_limit;
    crc_next    = running_crc;

    result_next.data_byte = c;
    result_next.in_frame  = 1'b1;
    result_next.status    = crc8fr_pkg::STATUS_NONE;

    case (phase)
      crc8fr_pkg::PHASE_HUNT: begin
        if (c == sync_byte) begin
          // Sync byte opens a frame and seeds the CRC.
          crc_next    = crc8fr_pkg::crc8_update(8'h00, c);
          count_next  = '0;
          length_next = '0;
          phase_next  = crc8fr_pkg::PHASE_LEN1;
        end else begin
          // Skip noise between frames.
          result_next.in_frame = 1'b0;
        end
      end
      crc8fr_pkg::PHASE_LEN1: begin
        length_next = len_full;
        crc_next    = crc_step;
        phase_next  = crc8fr_pkg::PHASE_LEN2;
      end
      crc8fr_pkg::PHASE_LEN2: begin
        length_next = len_full;
        crc_next    = crc_step;
        phase_next  = crc8fr_pkg::PHASE_LEN3;
      end
      crc8fr_pkg::PHASE_LEN3: begin
        length_next = len_full;
        crc_next    = crc_step;
        phase_next  = crc8fr_pkg::PHASE_LEN4;
      end
      crc8fr_pkg::PHASE_LEN4: begin
        length_next = len_full;
        crc_next    = crc_step;
        if (len_full >= crc8fr_pkg::MIN_LENGTH && len_full < max_length) begin
          // Precompute the data byte count so the data phase needs one compare.
          count_next = '0;
          limit_next = len_full - crc8fr_pkg::OVERHEAD;
          phase_next = crc8fr_pkg::PHASE_CMD;
        end else begin
          // Drop the frame and go back to hunting.
          result_next.status = crc8fr_pkg::STATUS_LEN_BAD;
          phase_next  = crc8fr_pkg::PHASE_HUNT;
          count_next  = '0;
          length_next = '0;
          crc_next    = '0;
        end
      end
      crc8fr_pkg::PHASE_CMD: begin
        crc_next   = crc_step;
        phase_next = crc8fr_pkg::PHASE_DATA;
      end
      crc8fr_pkg::PHASE_DATA: begin
        crc_next   = crc_step;
        count_next = byte_count + 32'd1;
        if (count_next >= data_limit) begin
          phase_next = crc8fr_pkg::PHASE_CRC;
        end
      end
      crc8fr_pkg::PHASE_CRC: begin
        // Trailing byte: commit on a CRC match, drop otherwise.
        result_next.status = (running_crc == c) ? crc8fr_pkg::STATUS_COMMIT
                                                : crc8fr_pkg::STATUS_CRC_BAD;
        phase_next  = crc8fr_pkg::PHASE_HUNT;
        count_next  = '0;
        length_next = '0;
        crc_next    = '0;
      end
      default: begin
        phase_next  = crc8fr_pkg::PHASE_HUNT;
        count_next  = '0;
        length_next = '0;
        crc_next    = '0;
      end
    endcase
  end

  // Advance the frame state on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= crc8fr_pkg::PHASE_HUNT;
      byte_count   <= '0;
      frame_length <= '0;
      data_limit   <= '0;
      running_crc  <= '0;
    end else if (rx_fire) begin
      phase        <= phase_next;
      byte_count   <= count_next;
      frame_length <= length_next;
      data_limit   <= limit_next;
      running_crc  <= crc_next;
    end
  end

  // Result register: load on accept, release when the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_fire) begin
      out_valid <= 1'b1;
    end else if (frame_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire) begin
      out_item <= result_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/crc8fr_checker.sv */
// ----------------------------------------------------------------------------
// crc8fr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crc8fr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_valid,
  input wire logic       rx_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_in_frame,
  input wire logic [1:0] out_status
);

  // Hold a stalled result.
  `AST_PROP(a_out_valid_holds, (out_valid && !out_ready) |=> out_valid)
  `AST_HOLD(a_out_payload_holds, out_valid, out_ready, {out_data_byte, out_in_frame, out_status})
  // Every accepted byte yields a result in the next cycle.
  `AST_PROP(a_result_follows, (rx_valid && rx_ready) |=> out_valid)
  // Commit or drop only ever marks a byte that belongs to the frame.
  `AST_PROP(a_status_in_frame, (out_valid && out_status != crc8fr_pkg::STATUS_NONE) |-> out_in_frame)

endmodule

bind crc8_length_frame_receiver crc8fr_checker u_crc8fr_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_valid      (rx_chan.valid),
  .rx_ready      (rx_chan.ready),
  .out_valid     (frame_chan.valid),
  .out_ready     (frame_chan.ready),
  .out_data_byte (frame_chan.payload.data_byte),
  .out_in_frame  (frame_chan.payload.in_frame),
  .out_status    (frame_chan.payload.status)
);

`default_nettype wire

/* test/crc8_length_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// crc8_length_frame_receiver_test
// Self-checking bench for the CRC-8 length-prefixed deframer. A byte-level
// tracker of the receiver predicts the data, in_frame mark and status of
// every byte. Directed cases and random frame traffic are checked in order,
// under random and held-off flow control on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8_length_frame_receiver_test;

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  crc8fr_stream_if #(.payload_t(crc8fr_pkg::rx_item_t)) rx_chan ();
  crc8fr_stream_if #(.payload_t(crc8fr_pkg::result_t))  frame_chan ();

  always #6 clk = ~clk;

  crc8_length_frame_receiver u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_chan    (rx_chan),
    .frame_chan (frame_chan)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  crc8fr_pkg::result_t pending_results[$];   // predicted results, oldest first
  int unsigned fail_count      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned hold_off_cycles = 0;  // one-shot long stall of the result side
  bit          sender_idle_on   = 1'b1;
  bit          receiver_idle_on = 1'b1;

  // Register copies and receiver tracker, advanced once per accepted byte.
  logic [7:0]         cfg_sync;
  logic [31:0]        cfg_max_len;
  crc8fr_pkg::phase_t trk_phase;
  logic [31:0]        trk_count;
  logic [31:0]        trk_length;
  logic [7:0]         trk_crc;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Reflected CRC-8, polynomial 0x8C, one byte LSB first.
  function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ crc8fr_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  // Drop any partial frame and go back to hunting for the sync byte.
  function automatic void clear_tracker();
    trk_phase  = crc8fr_pkg::PHASE_HUNT;
    trk_count  = '0;
    trk_length = '0;
    trk_crc    = '0;
  endfunction

  // Work out the result of one received byte and advance the tracker.
  function automatic crc8fr_pkg::result_t deframe_byte(input logic [7:0] rx);
    crc8fr_pkg::result_t r;
    r.data_byte = rx;
    r.in_frame  = 1'b1;
    r.status    = crc8fr_pkg::STATUS_NONE;
    case (trk_phase)
      crc8fr_pkg::PHASE_HUNT: begin
        if (rx == cfg_sync) begin
          trk_crc    = crc8_maxim_step(8'h00, rx);
          trk_count  = '0;
          trk_length = '0;
          trk_phase  = crc8fr_pkg::PHASE_LEN1;
        end else begin
          // Stray byte outside a frame: pass it on unmarked.
          r.in_frame = 1'b0;
          clear_tracker();
        end
      end
      crc8fr_pkg::PHASE_LEN1, crc8fr_pkg::PHASE_LEN2, crc8fr_pkg::PHASE_LEN3: begin
        trk_length = {trk_length[23:0], rx};
        trk_crc    = crc8_maxim_step(trk_crc, rx);
        trk_phase  = (trk_phase == crc8fr_pkg::PHASE_LEN1) ? crc8fr_pkg::PHASE_LEN2 :
                     (trk_phase == crc8fr_pkg::PHASE_LEN2) ? crc8fr_pkg::PHASE_LEN3 :
                                                             crc8fr_pkg::PHASE_LEN4;
      end
      crc8fr_pkg::PHASE_LEN4: begin
        trk_length = {trk_length[23:0], rx};
        trk_crc    = crc8_maxim_step(trk_crc, rx);
        if (trk_length >= crc8fr_pkg::MIN_LENGTH && trk_length < cfg_max_len) begin
          trk_count = '0;
          trk_phase = crc8fr_pkg::PHASE_CMD;
        end else begin
          // Length out of range: this byte closes the rejected frame.
          r.status = crc8fr_pkg::STATUS_LEN_BAD;
          clear_tracker();
        end
      end
      crc8fr_pkg::PHASE_CMD: begin
        trk_crc   = crc8_maxim_step(trk_crc, rx);
        trk_phase = crc8fr_pkg::PHASE_DATA;
      end
      crc8fr_pkg::PHASE_DATA: begin
        trk_crc   = crc8_maxim_step(trk_crc, rx);
        trk_count = trk_count + 32'd1;
        if (trk_count >= trk_length - crc8fr_pkg::OVERHEAD) begin
          trk_phase = crc8fr_pkg::PHASE_CRC;
        end
      end
      default: begin
        r.status = (trk_crc == rx) ? crc8fr_pkg::STATUS_COMMIT
                                   : crc8fr_pkg::STATUS_CRC_BAD;
        clear_tracker();
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_result(input crc8fr_pkg::result_t got);
    crc8fr_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %02h with nothing expected", got.data_byte));
      return;
    end
    want = pending_results.pop_front();
    if (got.data_byte !== want.data_byte) begin
      report_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
    end
    if (got.in_frame !== want.in_frame) begin
      report_mismatch($sformatf("in_frame %b on byte %02h, want %b",
                                got.in_frame, want.data_byte, want.in_frame));
    end
    if (got.status !== want.status) begin
      report_mismatch($sformatf("status %0d on byte %02h, want %0d",
                                got.status, want.data_byte, want.status));
    end
  endtask

  // Result side: stall at random, or hold off for a long stretch on request,
  // then accept one result and check it.
  initial begin : result_sink
    int unsigned stall;
    frame_chan.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_cycles > 0) begin
        frame_chan.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = receiver_idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        frame_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_chan.ready <= 1'b1;
      do @(posedge clk); while (!frame_chan.valid);
      check_result(frame_chan.payload);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one byte request after a random gap; predict it once it is taken.
  task automatic send_byte(input logic [7:0] value);
    int unsigned          gap;
    crc8fr_pkg::rx_item_t item;
    gap = sender_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      rx_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.rx_byte = value;
    rx_chan.valid   <= 1'b1;
    rx_chan.payload <= item;
    do @(posedge clk); while (!rx_chan.ready);
    bytes_sent++;
    pending_results.push_back(deframe_byte(value));
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic await_all_results();
    rx_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register between requests, keeping the local copy in step.
  task automatic write_register(input logic [0:0] index, input logic [31:0] value);
    await_all_results();
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (index == crc8fr_pkg::CFG_SYNC_BYTE) begin
      cfg_sync = value[7:0];
    end else begin
      cfg_max_len = value;
    end
  endtask

  // Send a frame with its own CRC. Stop after the header if the length is
  // out of range, or before body byte number cut when cut is not negative.
  task automatic send_frame(input logic [31:0] len, input bit corrupt, input int cut);
    logic [7:0]  crc;
    logic [7:0]  b;
    logic [39:0] header;
    header = {cfg_sync, len};
    crc    = 8'h00;
    for (int i = 4; i >= 0; i--) begin
      b   = header[i*8 +: 8];
      crc = crc8_maxim_step(crc, b);
      send_byte(b);
    end
    if (len < crc8fr_pkg::MIN_LENGTH || len >= cfg_max_len) return;
    for (int i = 0; i < int'(len) - 1; i++) begin
      if (i == cut) return;
      b   = 8'($urandom);
      crc = crc8_maxim_step(crc, b);
      send_byte(b);
    end
    send_byte(corrupt ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc);
  endtask

  // Bytes outside any frame. Keep the sync value out while the length limit
  // is large, so a random header cannot open a frame millions of bytes long.
  task automatic send_noise(input int unsigned count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom);
      if (b == cfg_sync && cfg_max_len > 64) b = ~b;
      send_byte(b);
    end
  endtask

  // Feed filler until the receiver hunts again; close a pending frame with
  // its right CRC unless asked to corrupt it.
  task automatic resync_tracker(input bit corrupt);
    while (trk_phase != crc8fr_pkg::PHASE_HUNT) begin
      if (trk_phase == crc8fr_pkg::PHASE_CRC) begin
        send_byte(corrupt ? ~trk_crc : trk_crc);
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  function automatic logic [31:0] pick_good_length(input int unsigned hi);
    logic [31:0] cap;
    cap = (cfg_max_len - 32'd1 < hi) ? cfg_max_len - 32'd1 : hi;
    return $urandom_range(crc8fr_pkg::MIN_LENGTH, cap);
  endfunction

  function automatic logic [31:0] pick_reject_length();
    longint unsigned span;
    span = 64'h1_0000_0000 - cfg_max_len;
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 2);
      1:       return cfg_max_len;
      2:       return 32'hFFFF_FFFF;
      default: return cfg_max_len + 32'({$urandom} % span);
    endcase
  endfunction

  // New random register setting and flow-control mode for the next stretch.
  task automatic pick_random_setting();
    logic [31:0] max_len;
    resync_tracker($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       max_len = crc8fr_pkg::MIN_LENGTH;
      1:       max_len = 32'd4;
      2, 3:    max_len = $urandom_range(5, 40);
      4:       max_len = crc8fr_pkg::MAX_LENGTH_RESET;
      5:       max_len = 32'hFFFF_FFFF;
      6:       max_len = ($urandom < 3) ? crc8fr_pkg::MIN_LENGTH : $urandom;
      default: max_len = $urandom_range(20, 400);
    endcase
    if ($urandom_range(0, 3) != 0) begin
      write_register(crc8fr_pkg::CFG_SYNC_BYTE, $urandom_range(0, 255));
    end
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, max_len);
    sender_idle_on   = ($urandom_range(0, 3) != 0);
    receiver_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: stray bytes, good and bad CRC, lengths at both limits.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(crc8fr_pkg::MIN_LENGTH, 1'b0, -1);
    send_frame(crc8fr_pkg::MIN_LENGTH, 1'b1, -1);
    send_frame(32'd2, 1'b0, -1);
    send_frame(crc8fr_pkg::MAX_LENGTH_RESET, 1'b0, -1);
  endtask

  // Register extremes: a limit of 3 rejects every frame, full-range limit,
  // sync values at both ends.
  task automatic test_register_extremes();
    write_register(crc8fr_pkg::CFG_SYNC_BYTE, 32'h00);
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, crc8fr_pkg::MIN_LENGTH);
    send_frame(crc8fr_pkg::MIN_LENGTH, 1'b0, -1);
    send_byte(crc8fr_pkg::SYNC_BYTE_RESET);
    write_register(crc8fr_pkg::CFG_SYNC_BYTE, 32'hFF);
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, 32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF, 1'b0, -1);
    send_frame(32'd4, 1'b0, -1);
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, 32'd4);
    send_frame(crc8fr_pkg::MIN_LENGTH, 1'b0, -1);
    send_frame(32'd4, 1'b0, -1);
  endtask

  // Change both registers while a frame is open; the open frame still
  // completes, the next one sees the new settings.
  task automatic test_register_write_mid_frame();
    write_register(crc8fr_pkg::CFG_SYNC_BYTE, 32'(crc8fr_pkg::SYNC_BYTE_RESET));
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, 32'd64);
    send_frame(32'd6, 1'b0, 2);
    write_register(crc8fr_pkg::CFG_SYNC_BYTE, 32'hA5);
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, crc8fr_pkg::MIN_LENGTH);
    resync_tracker(1'b0);
    send_frame(crc8fr_pkg::MIN_LENGTH, 1'b0, -1);
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the block fills and stalls its input.
  task automatic test_receiver_hold_off();
    write_register(crc8fr_pkg::CFG_MAX_LENGTH, 32'd64);
    sender_idle_on  = 1'b0;
    hold_off_cycles = 150;
    repeat (4) send_frame(pick_good_length(12), 1'b0, -1);
    sender_idle_on  = 1'b1;
    await_all_results();
  endtask

  // Pause the sender until every result is back, then carry on.
  task automatic test_sender_pause();
    send_frame(pick_good_length(10), 1'b0, -1);
    await_all_results();
    send_frame(pick_good_length(10), 1'b1, -1);
    await_all_results();
    send_frame(pick_good_length(10), 1'b0, -1);
  endtask

  // Mostly well-formed frames with random content; the rest bad CRCs,
  // rejected lengths, stray bytes and frames cut short before a resync.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned start;
    int unsigned stretch_end;
    int unsigned kind;
    logic [31:0] len;
    start       = bytes_sent;
    stretch_end = bytes_sent;
    while (bytes_sent - start < target) begin
      if (bytes_sent >= stretch_end) begin
        pick_random_setting();
        stretch_end = bytes_sent + $urandom_range(80, 250);
      end
      kind = $urandom_range(0, 99);
      // With no legal length, everything that needs one becomes a rejection.
      if (cfg_max_len <= crc8fr_pkg::MIN_LENGTH && (kind < 67 || kind >= 85)) kind = 80;
      if (kind < 55) begin
        send_frame(pick_good_length(18), 1'b0, -1);
      end else if (kind < 67) begin
        send_frame(pick_good_length(18), 1'b1, -1);
      end else if (kind < 75) begin
        send_noise($urandom_range(1, 3));
      end else if (kind < 85) begin
        send_frame(pick_reject_length(), 1'b0, -1);
      end else if (kind < 97 && cfg_max_len <= 400) begin
        // Cut a frame short, maybe drop a whole frame into its body, and
        // flush back to sync hunt.
        len = pick_good_length(18);
        send_frame(len, 1'b0, $urandom_range(0, int'(len) - 2));
        if ($urandom_range(0, 1) != 0) send_frame(pick_good_length(18), 1'b0, -1);
        resync_tracker($urandom_range(0, 1));
      end else begin
        send_frame(pick_good_length(300), 1'b0, -1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int unsigned drain_cycles;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= crc8fr_pkg::CFG_SYNC_BYTE;
    cfg_data         <= '0;
    rx_chan.valid    <= 1'b0;
    rx_chan.payload  <= '0;
    cfg_sync    = crc8fr_pkg::SYNC_BYTE_RESET;
    cfg_max_len = crc8fr_pkg::MAX_LENGTH_RESET;
    clear_tracker();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_register_write_mid_frame();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_traffic(2000);

    // Let the last results drain, with a bound, then allow for latency.
    rx_chan.valid <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("crc8_length_frame_receiver verification clean");
    end else begin
      $display("crc8_length_frame_receiver verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("crc8_length_frame_receiver verification failed");
    $finish;
  end

endmodule

/* crc8_length_frame_receiver.f */
+incdir+rtl
rtl/crc8fr_pkg.sv
rtl/crc8fr_stream_if.sv
rtl/crc8_length_frame_receiver.sv
rtl/crc8fr_checker.sv
test/crc8_length_frame_receiver_test.sv
